### rtl/lrul_pkg.sv
// shared types and constants for the recency list with pinned eviction
// opcode and status codes, per-cell control and per-transaction result
// no dependencies
package lrul_pkg;

    localparam int DEFAULT_DEPTH = 8;
    localparam int KEY_W         = 64;
    localparam int OP_W          = 2;
    localparam int SLOT_W        = 3;
    localparam int PIN_W         = 8;
    localparam int STAT_W        = 3;
    localparam int POS_W         = 3;
    localparam int CNT_OUT_W     = 4;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_FIND   = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_MOVED    = 3'd0,
        ST_INSERTED = 3'd1,
        ST_EVICTED  = 3'd2,
        ST_REJECTED = 3'd3,
        ST_DONE     = 3'd4,
        ST_IGNORED  = 3'd5
    } t_status;

    typedef struct packed {
        logic valid;
        logic take_prev;
        logic take_next;
    } t_cell_ctl;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [POS_W-1:0]   found_pos;
    } t_result;

endpackage

### rtl/lrul_cell.sv
// one list position: holds a key, compares it against the lookup key and
// shifts toward the front or back neighbor as the controller directs
// depends on lrul_pkg
module lrul_cell (
    input  logic                       i_clk,
    input  lrul_pkg::t_cell_ctl        i_ctl,
    input  logic [lrul_pkg::KEY_W-1:0] i_key,
    input  logic [lrul_pkg::KEY_W-1:0] i_prev_key,
    input  logic [lrul_pkg::KEY_W-1:0] i_next_key,
    output logic [lrul_pkg::KEY_W-1:0] o_key,
    output logic                       o_match
);
    import lrul_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;

    always_comb begin
        if (i_ctl.take_prev) begin
            n_key = i_prev_key;
        end else if (i_ctl.take_next) begin
            n_key = i_next_key;
        end else begin
            n_key = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key   = r_key;
    assign o_match = i_ctl.valid && (r_key == i_key);

endmodule

### rtl/lrul_ctrl.sv
// list controller: entry count, first-match and eviction search, and the
// shift commands sent to every cell
// depends on lrul_pkg
module lrul_ctrl #(
    parameter int LIST_DEPTH = lrul_pkg::DEFAULT_DEPTH,
    localparam int CNT_W = $clog2(LIST_DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [lrul_pkg::OP_W-1:0]   i_opcode,
    input  logic [lrul_pkg::SLOT_W-1:0] i_slot_index,
    input  logic [lrul_pkg::PIN_W-1:0]  i_pinned_mask,
    input  logic [LIST_DEPTH-1:0]       i_match,
    output lrul_pkg::t_cell_ctl         o_cell_ctl [LIST_DEPTH],
    output lrul_pkg::t_result           o_res,
    output logic [CNT_W-1:0]            o_next_count
);
    import lrul_pkg::*;

    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int PEXT_W = (LIST_DEPTH > PIN_W) ? LIST_DEPTH : PIN_W;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [PEXT_W-1:0] pins_ext;
    logic              hit;
    logic [IDX_W-1:0]  hit_pos;
    logic              got;
    logic [IDX_W-1:0]  ev_pos;
    logic              full;
    logic              shr_en;
    logic [IDX_W-1:0]  shr_pos;
    logic              shl_en;
    logic              slot_ok;

    // positions beyond the mask width have no pin bit
    assign pins_ext = PEXT_W'(i_pinned_mask);
    assign full     = (r_count == CNT_W'(LIST_DEPTH));
    assign slot_ok  = (CMP_W'(i_slot_index) < CMP_W'(r_count));

    // most recent match wins
    always_comb begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                hit     = 1'b1;
                hit_pos = IDX_W'(i);
            end
        end
    end

    // victim is the unpinned entry closest to the tail
    always_comb begin
        got    = 1'b0;
        ev_pos = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (!pins_ext[i]) begin
                got    = 1'b1;
                ev_pos = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_res.status    = ST_DONE;
        o_res.found     = 1'b0;
        o_res.found_pos = '0;
        n_count         = r_count;
        shr_en          = 1'b0;
        shr_pos         = IDX_W'(LIST_DEPTH - 1);
        shl_en          = 1'b0;
        case (t_opcode'(i_opcode))
            OP_PUSH: begin
                if (hit) begin
                    shr_en       = 1'b1;
                    shr_pos      = hit_pos;
                    o_res.status = ST_MOVED;
                end else if (full) begin
                    if (got) begin
                        shr_en       = 1'b1;
                        shr_pos      = ev_pos;
                        o_res.status = ST_EVICTED;
                    end else begin
                        o_res.status = ST_REJECTED;
                    end
                end else begin
                    shr_en       = 1'b1;
                    n_count      = r_count + 1'b1;
                    o_res.status = ST_INSERTED;
                end
            end
            OP_REMOVE: begin
                if (slot_ok) begin
                    shl_en  = 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    o_res.status = ST_IGNORED;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_FIND: begin
                o_res.found     = hit;
                o_res.found_pos = hit ? POS_W'(hit_pos) : '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // front part up to the boundary shifts back, from the slot on shifts forward
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            o_cell_ctl[i].valid     = (CMP_W'(i) < CMP_W'(r_count));
            o_cell_ctl[i].take_prev = i_fire && shr_en && (IDX_W'(i) <= shr_pos);
            o_cell_ctl[i].take_next = i_fire && shl_en &&
                                      (CMP_W'(i) >= CMP_W'(i_slot_index));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    assign o_next_count = n_count;

endmodule

### rtl/lru_list_with_pinned_eviction.sv
// recency-ordered key list with move-to-front and pinned-aware eviction
// input channel i_valid/o_stall, result channel o_valid/i_stall
// a transaction carries opcode (push, remove at index, clear, find), a key,
// a slot index and a pin mask; each one gives exactly one result transaction
// with status, find outcome, entry count and empty/full flags
// the result is registered and presented in the cycle after the input is accepted
// one transaction per cycle while the receiver does not stall; all compares run in parallel in the
// cell row and the shift happens in the same edge, so the single output
// register is the only thing that paces the stream
// when the receiver stalls, the result stays on the outputs and o_stall
// rises as well, so no new transaction enters until that result is taken
// reset (i_rst_n low at a clock edge) empties the list and drops any
// pending result; key storage is not cleared, only the count matters
// depends on lrul_pkg, lrul_cell and lrul_ctrl
module lru_list_with_pinned_eviction #(
    parameter int LIST_DEPTH = lrul_pkg::DEFAULT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lrul_pkg::OP_W-1:0]      i_opcode,
    input  logic [lrul_pkg::KEY_W-1:0]     i_key,
    input  logic [lrul_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic [lrul_pkg::PIN_W-1:0]     i_pinned_mask,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lrul_pkg::STAT_W-1:0]    o_status,
    output logic                           o_found,
    output logic [lrul_pkg::POS_W-1:0]     o_found_position,
    output logic [lrul_pkg::CNT_OUT_W-1:0] o_entry_count,
    output logic                           o_is_empty,
    output logic                           o_is_full
);
    import lrul_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    logic             in_fire;
    logic             out_load;
    t_cell_ctl        cell_ctl [LIST_DEPTH];
    logic [KEY_W-1:0] cell_key [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] match;
    t_result          res;
    logic [CNT_W-1:0] next_count;

    logic                 r_valid;
    logic [STAT_W-1:0]    r_status;
    logic                 r_found;
    logic [POS_W-1:0]     r_found_pos;
    logic [CNT_OUT_W-1:0] r_count;
    logic                 r_empty;
    logic                 r_full;

    assign out_load = !r_valid || !i_stall;
    assign o_stall  = !out_load;
    assign in_fire  = i_valid && out_load;

    lrul_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (in_fire),
        .i_opcode      (i_opcode),
        .i_slot_index  (i_slot_index),
        .i_pinned_mask (i_pinned_mask),
        .i_match       (match),
        .o_cell_ctl    (cell_ctl),
        .o_res         (res),
        .o_next_count  (next_count)
    );

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] prev_key;
        logic [KEY_W-1:0] next_key;

        // the front cell takes the incoming key, the tail cell keeps its own
        if (g == 0) begin : g_front
            assign prev_key = i_key;
        end else begin : g_mid
            assign prev_key = cell_key[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_tail
            assign next_key = cell_key[g];
        end else begin : g_body
            assign next_key = cell_key[g+1];
        end

        lrul_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl[g]),
            .i_key      (i_key),
            .i_prev_key (prev_key),
            .i_next_key (next_key),
            .o_key      (cell_key[g]),
            .o_match    (match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_load) begin
            r_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status    <= res.status;
            r_found     <= res.found;
            r_found_pos <= res.found_pos;
            r_count     <= CNT_OUT_W'(next_count);
            r_empty     <= (next_count == '0);
            r_full      <= (next_count == CNT_W'(LIST_DEPTH));
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_found          = r_found;
    assign o_found_position = r_found_pos;
    assign o_entry_count    = r_count;
    assign o_is_empty       = r_empty;
    assign o_is_full        = r_full;

`ifndef SYNTH
    // a clear always leaves an empty list in the next result
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_opcode == OP_CLEAR) |=> (o_valid && o_is_empty && !o_is_full))
        else $error("clear did not empty the list");

    // rejection only happens on a full list
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_REJECTED) |-> o_is_full)
        else $error("push rejected on a list that is not full");

    // eviction keeps the list full
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EVICTED) |-> (o_is_full && !o_is_empty))
        else $error("eviction left the list not full");

    // only find reports a hit
    a_found_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_opcode != OP_FIND) |=> !o_found)
        else $error("hit reported for an opcode other than find");
`endif

endmodule

### tb/sv/tb_lru_list_with_pinned_eviction.sv
// self-checking testbench for the recency list with pinned-aware eviction
// drives directed and random transactions and checks every result against
// a move-to-front list predictor; depends on lrul_pkg and the block's rtl
module tb_lru_list_with_pinned_eviction;
    import lrul_pkg::*;

    localparam int LIST_DEPTH  = DEFAULT_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 12;

    typedef struct {
        t_status        status;
        logic           found;
        logic [2:0]     position;
        logic [3:0]     count;
        logic           empty;
        logic           full;
    } t_list_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [OP_W-1:0]      i_opcode;
    logic [KEY_W-1:0]     i_key;
    logic [SLOT_W-1:0]    i_slot_index;
    logic [PIN_W-1:0]     i_pinned_mask;
    logic                 o_valid;
    logic                 i_stall;
    logic [STAT_W-1:0]    o_status;
    logic                 o_found;
    logic [POS_W-1:0]     o_found_position;
    logic [CNT_OUT_W-1:0] o_entry_count;
    logic                 o_is_empty;
    logic                 o_is_full;

    // predictor state
    logic [KEY_W-1:0] model_keys [LIST_DEPTH];
    int               model_count;

    t_list_result     pending_results [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               error_count;
    int unsigned      cycle_count;
    int               send_idle_pct;
    int               recv_stall_pct;

    lru_list_with_pinned_eviction #(
        .LIST_DEPTH(LIST_DEPTH)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_key            (i_key),
        .i_slot_index     (i_slot_index),
        .i_pinned_mask    (i_pinned_mask),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .o_is_full        (o_is_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_lru_list_with_pinned_eviction NOT OK");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void drop_key(int pos);
        for (int i = pos; i + 1 < model_count; i++) begin
            model_keys[i] = model_keys[i + 1];
        end
        model_count--;
    endfunction

    function automatic void insert_front(logic [KEY_W-1:0] key);
        for (int i = model_count; i > 0; i--) begin
            model_keys[i] = model_keys[i - 1];
        end
        model_keys[0] = key;
        model_count++;
    endfunction

    function automatic t_list_result apply_list_op(t_opcode op, logic [KEY_W-1:0] key,
                                                   logic [SLOT_W-1:0] slot,
                                                   logic [PIN_W-1:0] pins);
        t_list_result r;
        int           hit_pos;
        int           victim;
        r.status   = ST_DONE;
        r.found    = 1'b0;
        r.position = '0;
        hit_pos    = -1;
        victim     = -1;
        // most recent match wins
        for (int i = 0; i < model_count; i++) begin
            if (hit_pos < 0 && model_keys[i] == key) hit_pos = i;
        end
        case (op)
            OP_PUSH: begin
                if (hit_pos >= 0) begin
                    drop_key(hit_pos);
                    insert_front(key);
                    r.status = ST_MOVED;
                end else if (model_count >= LIST_DEPTH) begin
                    // scan from the tail for the last unpinned entry
                    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
                        if (victim < 0 && !(i < PIN_W && pins[i])) victim = i;
                    end
                    if (victim < 0) begin
                        r.status = ST_REJECTED;
                    end else begin
                        drop_key(victim);
                        insert_front(key);
                        r.status = ST_EVICTED;
                    end
                end else begin
                    insert_front(key);
                    r.status = ST_INSERTED;
                end
            end
            OP_REMOVE: begin
                if (int'(slot) < model_count) begin
                    drop_key(int'(slot));
                    r.status = ST_DONE;
                end else begin
                    r.status = ST_IGNORED;
                end
            end
            OP_CLEAR: begin
                model_count = 0;
                r.status    = ST_DONE;
            end
            default: begin
                if (hit_pos >= 0) begin
                    r.found    = 1'b1;
                    r.position = hit_pos[2:0];
                end
                r.status = ST_DONE;
            end
        endcase
        r.count = model_count[3:0];
        r.empty = (model_count == 0);
        r.full  = (model_count == LIST_DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (error_count < 200) begin
            $display("mismatch %s: got %0d expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        end
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", int'(o_status), -1);
            end else begin
                want = pending_results.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
                if (o_found != want.found)
                    report_mismatch("found", int'(o_found), int'(want.found));
                if (o_found_position != want.position)
                    report_mismatch("found_position", int'(o_found_position),
                                    int'(want.position));
                if (o_entry_count != want.count)
                    report_mismatch("entry_count", int'(o_entry_count), int'(want.count));
                if (o_is_empty != want.empty)
                    report_mismatch("is_empty", int'(o_is_empty), int'(want.empty));
                if (o_is_full != want.full)
                    report_mismatch("is_full", int'(o_is_full), int'(want.full));
            end
        end
    end

    // one transaction: random idle cycles first, then hold until accepted
    task automatic send_item(t_opcode op, logic [KEY_W-1:0] key,
                             logic [SLOT_W-1:0] slot, logic [PIN_W-1:0] pins);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_key   <= {$urandom, $urandom};
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_key         <= key;
        i_slot_index  <= slot;
        i_pinned_mask <= pins;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(apply_list_op(op, key, slot, pins));
    endtask

    task automatic test_push_and_find();
        send_item(OP_FIND, '0, '0, '0);
        send_item(OP_REMOVE, '0, 3'd0, '0);
        send_item(OP_PUSH, '0, 3'd0, '0);
        send_item(OP_PUSH, '1, 3'd7, '1);
        send_item(OP_PUSH, '0, 3'd0, '0);
        send_item(OP_FIND, '1, 3'd0, '0);
        send_item(OP_FIND, 64'h5555_5555_5555_5555, 3'd0, '0);
    endtask

    task automatic test_full_list_eviction();
        for (int i = 0; i < LIST_DEPTH - 2; i++) begin
            send_item(OP_PUSH, 64'hA5A5_0000_0000_0000 | i, 3'd7, '1);
        end
        // every entry pinned, then a present key under the same mask
        send_item(OP_PUSH, 64'hDEAD_BEEF_0000_0001, 3'd0, 8'hFF);
        send_item(OP_PUSH, '1, 3'd0, 8'hFF);
        send_item(OP_PUSH, 64'hDEAD_BEEF_0000_0002, 3'd0, 8'h80);
        send_item(OP_PUSH, 64'hDEAD_BEEF_0000_0003, 3'd0, 8'hFE);
        send_item(OP_PUSH, 64'hDEAD_BEEF_0000_0004, 3'd0, 8'h00);
        send_item(OP_FIND, 64'hDEAD_BEEF_0000_0004, 3'd0, '0);
        send_item(OP_FIND, 64'hA5A5_0000_0000_0001, 3'd0, '0);
    endtask

    task automatic test_remove_and_clear();
        send_item(OP_REMOVE, '0, 3'd7, '0);
        send_item(OP_REMOVE, '0, 3'd7, '0);
        send_item(OP_REMOVE, '1, 3'd0, 8'hFF);
        send_item(OP_CLEAR, '1, 3'd5, 8'hAA);
        send_item(OP_REMOVE, '0, 3'd0, '0);
        send_item(OP_PUSH, 64'h8000_0000_0000_0001, 3'd0, '0);
        send_item(OP_FIND, 64'h8000_0000_0000_0001, 3'd0, '0);
    endtask

    // keys mostly come from a small pool so hits, moves and evictions are common
    task automatic test_random_traffic(int n_items);
        int               pick;
        t_opcode          op;
        logic [KEY_W-1:0] key;
        logic [PIN_W-1:0] pins;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(49) == 0)
                key_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < 52)      op = OP_PUSH;
            else if (pick < 74) op = OP_FIND;
            else if (pick < 96) op = OP_REMOVE;
            else                op = OP_CLEAR;
            if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
            else                         key = {$urandom, $urandom};
            pick = $urandom_range(5);
            if (pick == 0)      pins = 8'hFF;
            else if (pick == 1) pins = 8'h00;
            else                pins = PIN_W'($urandom_range(255));
            send_item(op, key, SLOT_W'($urandom_range(7)), pins);
        end
    endtask

    initial begin
        error_count    = 0;
        model_count    = 0;
        send_idle_pct  = 26;
        recv_stall_pct = 62;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = '0;
        i_key          = '0;
        i_slot_index   = '0;
        i_pinned_mask  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_push_and_find();
        test_full_list_eviction();
        test_remove_and_clear();
        test_random_traffic(600);
        send_idle_pct  = 62;
        recv_stall_pct = 26;
        test_random_traffic(600);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(600);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_lru_list_with_pinned_eviction OK");
        end else begin
            $display("tb_lru_list_with_pinned_eviction NOT OK");
        end
        $finish;
    end

endmodule
